>>> rtl/etl_pkg.sv
`timescale 1ns / 1ps

package etl_pkg;

   // longest line the position and length counters are sized for
   localparam int MAX_LINE = 4096;

   localparam int POS_W = 12;
   localparam int LEN_W = 13;
   localparam int KIND_W = 4;
   localparam int STATUS_W = 2;

   // counters stop at these values on long lines
   localparam logic [POS_W-1:0] POS_CAP =
      POS_W'((MAX_LINE - 1) > 4095 ? 4095 : (MAX_LINE - 1));
   localparam logic [LEN_W-1:0] LEN_CAP =
      LEN_W'(MAX_LINE > 4096 ? 4096 : MAX_LINE);

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_TOKEN     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_TOKEN = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EOL_ONLY  = 2'd3;

   // token kind codes
   localparam logic [KIND_W-1:0] KIND_IDENT = 4'd0;
   localparam logic [KIND_W-1:0] KIND_INT   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_FLOAT = 4'd2;
   localparam logic [KIND_W-1:0] KIND_COMMA = 4'd3;
   localparam logic [KIND_W-1:0] KIND_OPEN  = 4'd4;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 4'd5;
   localparam logic [KIND_W-1:0] KIND_EQUAL = 4'd6;
   localparam logic [KIND_W-1:0] KIND_ADD   = 4'd7;
   localparam logic [KIND_W-1:0] KIND_SUB   = 4'd8;
   localparam logic [KIND_W-1:0] KIND_MUL   = 4'd9;
   localparam logic [KIND_W-1:0] KIND_DIV   = 4'd10;
   localparam logic [KIND_W-1:0] KIND_POW   = 4'd11;

   // queue between the front and the back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // one result item
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [KIND_W-1:0]   token_kind;
      logic [POS_W-1:0]    token_start;
      logic [LEN_W-1:0]    token_length;
      logic                last_of_line;
   } result_type;

   // all results of one input item: one or two
   typedef struct packed {
      logic       pair;
      result_type first;
      result_type second;
   } record_type;

endpackage

>>> rtl/etl_front.sv
`timescale 1ns / 1ps

module etl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_code,
   input  logic                line_end,
   output logic                rec_push,
   output etl_pkg::record_type rec_data
);
   import etl_pkg::*;

   typedef enum logic [3:0] {
      ST_ROOT, ST_IDENT, ST_INT, ST_DOT, ST_FLOAT,
      ST_COMMA, ST_OPEN, ST_CLOSE, ST_EQUAL, ST_ADD, ST_SUB, ST_MUL, ST_DIV, ST_POW
   } state_type;

   typedef enum logic [3:0] {
      CL_LETTER, CL_DIGIT, CL_DOT,
      CL_COMMA, CL_OPEN, CL_CLOSE, CL_EQUAL, CL_ADD, CL_SUB, CL_MUL, CL_DIV, CL_POW,
      CL_SPACE, CL_BAD
   } class_type;

   // sort one byte into its character class
   function automatic class_type classify(input logic [7:0] c);
      class_type cl;
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") cl = CL_LETTER;
      else if (c >= "0" && c <= "9") cl = CL_DIGIT;
      else if (c == ".") cl = CL_DOT;
      else if (c == " ") cl = CL_SPACE;
      else if (c == ",") cl = CL_COMMA;
      else if (c == "(") cl = CL_OPEN;
      else if (c == ")") cl = CL_CLOSE;
      else if (c == "=") cl = CL_EQUAL;
      else if (c == "+") cl = CL_ADD;
      else if (c == "-") cl = CL_SUB;
      else if (c == "*") cl = CL_MUL;
      else if (c == "/") cl = CL_DIV;
      else if (c == "^") cl = CL_POW;
      else cl = CL_BAD;
      return cl;
   endfunction

   // token kind reported for a finished state
   function automatic logic [KIND_W-1:0] kind_of(input state_type st);
      logic [KIND_W-1:0] k;
      unique case (st)
         ST_IDENT: k = KIND_IDENT;
         ST_INT:   k = KIND_INT;
         ST_FLOAT: k = KIND_FLOAT;
         ST_COMMA: k = KIND_COMMA;
         ST_OPEN:  k = KIND_OPEN;
         ST_CLOSE: k = KIND_CLOSE;
         ST_EQUAL: k = KIND_EQUAL;
         ST_ADD:   k = KIND_ADD;
         ST_SUB:   k = KIND_SUB;
         ST_MUL:   k = KIND_MUL;
         ST_DIV:   k = KIND_DIV;
         ST_POW:   k = KIND_POW;
         default:  k = KIND_IDENT;
      endcase
      return k;
   endfunction

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              drop_ff, drop_in;

   class_type         cls;
   state_type         root_state;
   logic              root_err;
   logic              root_skip;
   logic              grows;
   state_type         grow_state;
   result_type        res [2];
   logic [1:0]        cnt;

   // decode of a byte seen between tokens
   always_comb begin
      cls = classify(char_code);
      root_err = 1'b0;
      root_skip = 1'b0;
      root_state = ST_ROOT;
      unique case (cls)
         CL_LETTER: root_state = ST_IDENT;
         CL_DIGIT:  root_state = ST_INT;
         CL_COMMA:  root_state = ST_COMMA;
         CL_OPEN:   root_state = ST_OPEN;
         CL_CLOSE:  root_state = ST_CLOSE;
         CL_EQUAL:  root_state = ST_EQUAL;
         CL_ADD:    root_state = ST_ADD;
         CL_SUB:    root_state = ST_SUB;
         CL_MUL:    root_state = ST_MUL;
         CL_DIV:    root_state = ST_DIV;
         CL_POW:    root_state = ST_POW;
         CL_SPACE:  root_skip = 1'b1;
         default:   root_err = 1'b1;
      endcase
   end

   // can the byte extend the current token
   always_comb begin
      grows = 1'b0;
      grow_state = state_ff;
      unique case (state_ff)
         ST_IDENT: begin
            if (cls == CL_LETTER || cls == CL_DIGIT) begin
               grows = 1'b1;
               grow_state = ST_IDENT;
            end
         end
         ST_INT: begin
            if (cls == CL_DIGIT) begin
               grows = 1'b1;
               grow_state = ST_INT;
            end else if (cls == CL_DOT) begin
               grows = 1'b1;
               grow_state = ST_DOT;
            end
         end
         ST_DOT, ST_FLOAT: begin
            if (cls == CL_DIGIT) begin
               grows = 1'b1;
               grow_state = ST_FLOAT;
            end
         end
         default: grows = 1'b0;
      endcase
   end

   // one automaton step, collecting up to two results
   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      start_in = start_ff;
      len_in = len_ff;
      drop_in = drop_ff;
      res[0] = '0;
      res[1] = '0;
      cnt = 2'd0;
      if (accept) begin
         if (!drop_ff) begin
            if (state_ff != ST_ROOT) begin
               if (grows) begin
                  state_in = grow_state;
                  if (len_ff < LEN_CAP) len_in = len_ff + 1'b1;
               end else begin
                  // close the pending token, a dangling dot is an error
                  res[0].status = (state_ff == ST_DOT) ? STATUS_BAD_TOKEN : STATUS_TOKEN;
                  res[0].token_kind = kind_of(state_ff);
                  res[0].token_start = start_ff;
                  res[0].token_length = len_ff;
                  cnt = 2'd1;
                  state_in = ST_ROOT;
                  if (state_ff == ST_DOT) drop_in = 1'b1;
               end
            end
            if (state_ff == ST_ROOT || (!grows && state_ff != ST_DOT)) begin
               if (root_err) begin
                  res[cnt[0]].status = STATUS_BAD_CHAR;
                  res[cnt[0]].token_kind = KIND_IDENT;
                  res[cnt[0]].token_start = pos_ff;
                  res[cnt[0]].token_length = LEN_W'(1);
                  cnt = cnt + 2'd1;
                  drop_in = 1'b1;
               end else if (!root_skip) begin
                  state_in = root_state;
                  start_in = pos_ff;
                  len_in = LEN_W'(1);
               end
            end
            if (pos_ff < POS_CAP) pos_in = pos_ff + 1'b1;
            if (drop_in) state_in = ST_ROOT;
         end
         if (line_end) begin
            // close the line with exactly one last result
            if (state_in != ST_ROOT) begin
               res[cnt[0]].status =
                  (state_in == ST_DOT) ? STATUS_BAD_TOKEN : STATUS_TOKEN;
               res[cnt[0]].token_kind = kind_of(state_in);
               res[cnt[0]].token_start = start_in;
               res[cnt[0]].token_length = len_in;
               res[cnt[0]].last_of_line = 1'b1;
               cnt = cnt + 2'd1;
            end else if (cnt == 2'd1) begin
               res[0].last_of_line = 1'b1;
            end else if (cnt == 2'd2) begin
               res[1].last_of_line = 1'b1;
            end else begin
               res[0].status = STATUS_EOL_ONLY;
               res[0].last_of_line = 1'b1;
               cnt = 2'd1;
            end
            state_in = ST_ROOT;
            pos_in = '0;
            start_in = '0;
            len_in = '0;
            drop_in = 1'b0;
         end
      end
   end

   assign rec_push = (cnt != 2'd0);
   assign rec_data.pair = cnt[1];
   assign rec_data.first = res[0];
   assign rec_data.second = res[1];

   // automaton state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ROOT;
         pos_ff <= '0;
         start_ff <= '0;
         len_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         start_ff <= start_in;
         len_ff <= len_in;
         drop_ff <= drop_in;
      end
   end

endmodule

>>> rtl/etl_queue.sv
`timescale 1ns / 1ps

module etl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  etl_pkg::record_type wr_data,
   output logic                full,
   input  logic                rd_en,
   output logic                rd_valid,
   output etl_pkg::record_type rd_data
);
   import etl_pkg::*;

   record_type           mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 do_wr;
   logic                 do_rd;

   assign full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data = mem[rd_ptr_ff];
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && rd_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (!do_wr && do_rd) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_wr) mem[wr_ptr_ff] <= wr_data;
   end

endmodule

>>> rtl/etl_back.sv
`timescale 1ns / 1ps

module etl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                rec_valid,
   input  etl_pkg::record_type rec_data,
   output logic                rec_take,
   input  logic                out_pop,
   output logic                out_empty,
   output etl_pkg::result_type out_data
);
   import etl_pkg::*;

   record_type hold_ff, hold_in;
   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   logic       popped;
   logic       done;

   assign out_empty = !valid_ff;
   assign out_data = phase_ff ? hold_ff.second : hold_ff.first;
   assign popped = out_pop && valid_ff;
   assign done = popped && (!hold_ff.pair || phase_ff);
   assign rec_take = rec_valid && (!valid_ff || done);

   // step through the one or two results of the held record
   always_comb begin
      hold_in = hold_ff;
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (rec_take) begin
         hold_in = rec_data;
         valid_in = 1'b1;
         phase_in = 1'b0;
      end else if (done) begin
         valid_in = 1'b0;
         phase_in = 1'b0;
      end else if (popped) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

>>> rtl/expression_token_lexer_top.sv
`timescale 1ns / 1ps
// channel  | ports                                            | handshake
// ---------+--------------------------------------------------+---------------------------
// request  | req_char_code, req_line_end                      | push / full
// response | rsp_status, rsp_token_kind, rsp_token_start,     | empty / pop
//          | rsp_token_length, rsp_last_of_line               |
//
// one character is taken per cycle while full is low; the automaton step finishes in the cycle it is taken
// each character yields zero, one or two items, held in a four-entry record queue
// the back end delivers one item per cycle while pop is high, so a run of two-item characters fills the queue
// full rises only when the record queue is full; results wait in the back end's register
// reset is synchronous and clears the automaton, the queue and the output stage

module expression_token_lexer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [7:0]                     req_char_code,
   input  logic                           req_line_end,
   output logic                           empty,
   input  logic                           pop,
   output logic [etl_pkg::STATUS_W-1:0]   rsp_status,
   output logic [etl_pkg::KIND_W-1:0]     rsp_token_kind,
   output logic [etl_pkg::POS_W-1:0]      rsp_token_start,
   output logic [etl_pkg::LEN_W-1:0]      rsp_token_length,
   output logic                           rsp_last_of_line
);
   import etl_pkg::*;

   logic       accept;
   logic       rec_push;
   record_type rec_in;
   logic       q_valid;
   record_type q_data;
   logic       q_take;
   result_type out_data;

   assign accept = push && !full;

   // front: classify and step the automaton
   etl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .line_end  (req_line_end),
      .rec_push  (rec_push),
      .rec_data  (rec_in)
   );

   // record queue between front and back
   etl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rec_push),
      .wr_data  (rec_in),
      .full     (full),
      .rd_en    (q_take),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   // back: deliver results one item at a time
   etl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (q_valid),
      .rec_data  (q_data),
      .rec_take  (q_take),
      .out_pop   (pop),
      .out_empty (empty),
      .out_data  (out_data)
   );

   assign rsp_status = out_data.status;
   assign rsp_token_kind = out_data.token_kind;
   assign rsp_token_start = out_data.token_start;
   assign rsp_token_length = out_data.token_length;
   assign rsp_last_of_line = out_data.last_of_line;

endmodule

>>> verif/expression_token_lexer_top_tb.sv
`timescale 1ns / 1ps

module expression_token_lexer_top_tb;
   import etl_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_CHARS = 400;
   localparam int SETTLE_CYCLES = 20;

   // character classes
   localparam logic [3:0] CL_LETTER = 4'd0;
   localparam logic [3:0] CL_DIGIT  = 4'd1;
   localparam logic [3:0] CL_DOT    = 4'd2;
   localparam logic [3:0] CL_PUNCT  = 4'd3;
   localparam logic [3:0] CL_SPACE  = 4'd12;
   localparam logic [3:0] CL_BAD    = 4'd13;

   // automaton states, punctuators follow LX_PUNCT in kind order
   localparam logic [3:0] LX_ROOT  = 4'd0;
   localparam logic [3:0] LX_IDENT = 4'd1;
   localparam logic [3:0] LX_INT   = 4'd2;
   localparam logic [3:0] LX_DOT   = 4'd3;
   localparam logic [3:0] LX_FLOAT = 4'd4;
   localparam logic [3:0] LX_PUNCT = 4'd5;

   localparam string PUNCT_CHARS = ",()=+-*/^";

   typedef struct {
      logic [7:0] code;
      logic       line_end;
      bit         wait_idle;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [7:0] req_char_code = 8'd0;
   logic req_line_end = 1'b0;
   logic empty;
   logic pop = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [KIND_W-1:0] rsp_token_kind;
   logic [POS_W-1:0] rsp_token_start;
   logic [LEN_W-1:0] rsp_token_length;
   logic rsp_last_of_line;

   char_item_type pending_chars[$];
   logic [7:0] line_buf[$];
   result_type expected_tokens[$];
   result_type step_tokens[$];

   // lexer prediction state
   logic [3:0] lx_state;
   logic [POS_W-1:0] char_pos;
   logic [POS_W-1:0] tok_start;
   logic [LEN_W-1:0] tok_len;
   bit dropping;

   bit failed = 1'b0;
   int cycle_count = 0;
   int gap_left = 0;
   int burst_left = 0;
   int pop_mode = 0;
   int pop_mode_left = 0;
   int pop_tick = 0;
   int random_chars = 0;

   expression_token_lexer_top dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_char_code(req_char_code),
      .req_line_end(req_line_end),
      .empty(empty),
      .pop(pop),
      .rsp_status(rsp_status),
      .rsp_token_kind(rsp_token_kind),
      .rsp_token_start(rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_last_of_line(rsp_last_of_line)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic logic [3:0] char_class(logic [7:0] c);
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") return CL_LETTER;
      if (c >= "0" && c <= "9") return CL_DIGIT;
      if (c == ".") return CL_DOT;
      if (c == " ") return CL_SPACE;
      for (int k = 0; k < 9; k++)
         if (c == PUNCT_CHARS[k]) return 4'(CL_PUNCT + k);
      return CL_BAD;
   endfunction

   // -1 when the class cannot extend the state
   function automatic int lex_next(logic [3:0] st, logic [3:0] cl);
      case (st)
         LX_ROOT: begin
            if (cl == CL_SPACE) return LX_ROOT;
            if (cl == CL_LETTER) return LX_IDENT;
            if (cl == CL_DIGIT) return LX_INT;
            if (cl >= CL_PUNCT && cl < CL_SPACE) return LX_PUNCT + (cl - CL_PUNCT);
            return -1;
         end
         LX_IDENT: return (cl == CL_LETTER || cl == CL_DIGIT) ? LX_IDENT : -1;
         LX_INT: begin
            if (cl == CL_DIGIT) return LX_INT;
            if (cl == CL_DOT) return LX_DOT;
            return -1;
         end
         LX_DOT, LX_FLOAT: return (cl == CL_DIGIT) ? LX_FLOAT : -1;
         default: return -1;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] kind_for(logic [3:0] st);
      if (st == LX_IDENT) return KIND_IDENT;
      if (st == LX_INT) return KIND_INT;
      if (st == LX_FLOAT) return KIND_FLOAT;
      if (st >= LX_PUNCT) return KIND_COMMA + (st - LX_PUNCT);
      return KIND_IDENT;
   endfunction

   function automatic void add_token(logic [STATUS_W-1:0] status, logic [KIND_W-1:0] kind,
                                     logic [POS_W-1:0] start, logic [LEN_W-1:0] len,
                                     logic last);
      result_type r;
      r.status = status;
      r.token_kind = kind;
      r.token_start = start;
      r.token_length = len;
      r.last_of_line = last;
      step_tokens.insert(step_tokens.size(), r);
   endfunction

   function automatic void clear_lexer();
      lx_state = LX_ROOT;
      char_pos = '0;
      tok_start = '0;
      tok_len = '0;
      dropping = 1'b0;
   endfunction

   // emit the pending token, a dangling dot is an invalid token
   function automatic void settle_token(logic last);
      if (lx_state == LX_DOT) begin
         add_token(STATUS_BAD_TOKEN, KIND_IDENT, tok_start, tok_len, last);
         dropping = 1'b1;
      end else begin
         add_token(STATUS_TOKEN, kind_for(lx_state), tok_start, tok_len, last);
      end
      lx_state = LX_ROOT;
   endfunction

   function automatic void begin_token(logic [3:0] cl, logic [POS_W-1:0] pos);
      int nx;
      nx = lex_next(LX_ROOT, cl);
      if (nx < 0) begin
         add_token(STATUS_BAD_CHAR, KIND_IDENT, pos, LEN_W'(1), 1'b0);
         dropping = 1'b1;
      end else if (nx != LX_ROOT) begin
         lx_state = 4'(nx);
         tok_start = pos;
         tok_len = LEN_W'(1);
      end
   endfunction

   // one character through the lexer, expected items queued in order
   function automatic void lex_char(logic [7:0] c, logic eol);
      int nx;
      logic [3:0] cl;
      step_tokens.delete();
      if (!dropping) begin
         cl = char_class(c);
         if (lx_state == LX_ROOT) begin
            begin_token(cl, char_pos);
         end else begin
            nx = lex_next(lx_state, cl);
            if (nx >= 0) begin
               lx_state = 4'(nx);
               if (tok_len < LEN_CAP) tok_len++;
            end else begin
               settle_token(1'b0);
               if (!dropping) begin_token(cl, char_pos);
            end
         end
         if (char_pos < POS_CAP) char_pos++;
         if (dropping) lx_state = LX_ROOT;
      end
      // every line closes with exactly one last item
      if (eol) begin
         if (lx_state != LX_ROOT)
            settle_token(1'b1);
         else if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_line = 1'b1;
         else
            add_token(STATUS_EOL_ONLY, KIND_IDENT, '0, '0, 1'b1);
         clear_lexer();
      end
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void put_char(logic [7:0] c);
      line_buf.insert(line_buf.size(), c);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endfunction

   function automatic void end_line(bit wait_idle);
      char_item_type it;
      foreach (line_buf[i]) begin
         it.code = line_buf[i];
         it.line_end = (i == line_buf.size() - 1);
         it.wait_idle = wait_idle && (i == 0);
         pending_chars.insert(pending_chars.size(), it);
      end
      line_buf.delete();
   endfunction

   function automatic logic [7:0] rand_letter();
      int k;
      k = $urandom_range(0, 52);
      if (k < 26) return 8'("A" + k);
      if (k < 52) return 8'("a" + k - 26);
      return "_";
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic void put_digits(int lo, int hi);
      repeat ($urandom_range(lo, hi)) put_char(rand_digit());
   endfunction

   // mostly well-formed tokens, some noise and broken floats
   function automatic void put_random_token();
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            put_char(rand_letter());
            repeat ($urandom_range(0, 5))
               put_char($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
         end
         3, 4: put_digits(1, 4);
         5, 6: begin
            put_digits(1, 3);
            put_char(".");
            put_digits(1, 3);
         end
         7, 8, 9: put_char(PUNCT_CHARS[$urandom_range(0, 8)]);
         10: begin
            put_digits(1, 2);
            put_char(".");
         end
         default: put_char(8'($urandom_range(0, 255)));
      endcase
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) put_char(" ");
   endfunction

   // ---------------------------------------------------------------- field check

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         failed = 1'b1;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin : char_driver
      bit take;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) lex_char(req_char_code, req_line_end);
         take = !push || !full;
         if (take) begin
            if (gap_left > 0) begin
               gap_left--;
               push <= 1'b0;
            end else if (pending_chars.size() > 0 &&
                         !(pending_chars[0].wait_idle && expected_tokens.size() > 0)) begin
               req_char_code <= pending_chars[0].code;
               req_line_end <= pending_chars[0].line_end;
               push <= 1'b1;
               void'(pending_chars.pop_front());
               // new burst and gap once the current burst is spent
               if (burst_left > 0) begin
                  burst_left--;
               end else if ($urandom_range(0, 7) == 0) begin
                  gap_left = 0;
                  burst_left = 200;
               end else begin
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                  burst_left = $urandom_range(1, 24);
               end
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : token_monitor
      result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_tokens.size() == 0) begin
               failed = 1'b1;
               $error("item with none expected: status %0d kind %0d start %0d len %0d",
                      rsp_status, rsp_token_kind, rsp_token_start, rsp_token_length);
            end else begin
               want = expected_tokens.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_status));
               check_field("token_kind", 16'(want.token_kind), 16'(rsp_token_kind));
               check_field("token_start", 16'(want.token_start), 16'(rsp_token_start));
               check_field("token_length", 16'(want.token_length), 16'(rsp_token_length));
               check_field("last_of_line", 16'(want.last_of_line), 16'(rsp_last_of_line));
            end
         end
         // stall pattern: steady, coin flip, or a regular pop paced by pop_tick
         if (pop_mode_left == 0) begin
            pop_mode = $urandom_range(0, 2);
            pop_mode_left = $urandom_range(20, 80);
         end else begin
            pop_mode_left--;
         end
         pop_tick++;
         case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default: pop <= (pop_tick % 4 == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_lexer();

      // directed lines
      put_text("Az_9=0.5 ");          // ident, equal, float, trailing space
      end_line(1'b0);
      put_text(",()+-*/^");           // every punctuator but '=', last one at line end
      end_line(1'b0);
      put_text("1.x");                // digits and dot without a digit after
      end_line(1'b0);
      put_text(" ");                  // nothing but the line end
      end_line(1'b0);
      put_char(8'hFF);                // invalid byte, rest of line dropped
      put_text("a");
      end_line(1'b0);
      put_text("7.");                 // dangling dot at line end
      end_line(1'b0);

      // random lines, the first and some others wait for the block to drain
      while (random_chars < RANDOM_CHARS) begin
         if ($urandom_range(0, 14) == 0) begin
            repeat ($urandom_range(1, 10)) put_char(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 8)) put_random_token();
         end
         random_chars += line_buf.size();
         end_line(random_chars == line_buf.size() || $urandom_range(0, 9) == 0);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (pending_chars.size() != 0 || push);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (!failed)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
